// File: sv/dcmf_pkg.sv
// Shared types and constants for the dark channel minimum filter.
// No dependencies; every other file but dcmf_ram imports this package.
package dcmf_pkg;

    localparam int DATA_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int RAD_CFG_W = 3;

    localparam logic [DATA_W-1:0] PIX_MAX = '1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_RADIUS = 2'd2;

    typedef logic [DATA_W-1:0] pix_t;

endpackage

// File: sv/dcmf_if.sv
// Stream interfaces: pixel input channel and dark-channel result channel.
// Depends on dcmf_pkg.
interface dcmf_in_if
    import dcmf_pkg::*;
;
    logic valid;
    logic ready;
    logic cmd;
    pix_t blue;
    pix_t green;
    pix_t red;

    modport source (output valid, cmd, blue, green, red, input ready);
    modport sink (input valid, cmd, blue, green, red, output ready);
endinterface

interface dcmf_out_if
    import dcmf_pkg::*;
;
    logic valid;
    logic ready;
    pix_t dark;
    logic end_of_line;
    logic end_of_frame;

    modport source (output valid, dark, end_of_line, end_of_frame, input ready);
    modport sink (input valid, dark, end_of_line, end_of_frame, output ready);
endinterface

// File: sv/dark_channel_min_filter.sv
// Dark channel minimum filter: per-pixel channel minimum followed by a
// clipped square minimum window. Depends on dcmf_pkg, dcmf_if, dcmf_ram,
// dcmf_min_tree and dcmf_cell.
//
// Usage: pixels enter on the pixel channel in raster order (cmd pixel),
// results leave on the result channel in raster order with line and frame
// end flags. After the last pixel of a frame, send flush transfers until
// the result with end_of_frame arrives; a pixel sent before then is dropped.
// Registers are written on the cfg port and take effect at the first pixel
// of the next frame.
// Sequencing: a pixel is written to its line bank and, when a column minimum
// is due, read through the registered RAM port, reduced, shifted into the
// window chain and resolved; a flush skips the write, and an ignored item
// is only accepted. The pixel channel is ready only between items.
// Output: a result leaves in the emit state of the item that completes its
// window, fr lines and fr pixels after its own pixel, clipped at the borders.
// The output register holds a result while the receiver stalls; the next
// item is still accepted and only waits in its emit state.
// Reset clears all counters and sets the window cells to 255; the line
// banks need no clearing.
module dark_channel_min_filter
    import dcmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dcmf_in_if.sink              pixel,
    dcmf_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int WIN = 2 * MAX_RADIUS + 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int LW  = $clog2(MAX_HEIGHT) + 1;
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int BW  = $clog2(WIN);
    localparam int KW  = $clog2(2 * WIN) + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_VM   = 3'd3;
    localparam logic [2:0] S_SH   = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CFG_W-1:0]     cfg_w_reg, cfg_h_reg;
    logic [RAD_CFG_W-1:0] cfg_r_reg;
    logic [CW:0]          fw_reg;
    logic [LW-1:0]        fh_reg;
    logic [RW-1:0]        fr_reg;
    logic [CW-1:0]        in_col_reg, cm_col_reg, out_col_reg;
    logic [LW-1:0]        in_line_reg, cm_line_reg, out_line_reg;
    logic [BW-1:0]        in_mod_reg, cm_mod_reg;
    logic [KW-1:0]        lead_reg;
    logic                 draining_reg;
    pix_t                 mn_reg, vmin_reg;
    logic                 out_valid_reg, eol_reg, eof_reg;
    pix_t                 dark_reg;

    logic accept, first_pix, out_free;
    pix_t mn_bg, mn;

    assign pixel.ready = (state_reg == S_IDLE);
    assign accept      = pixel.valid && pixel.ready;
    assign mn_bg       = (pixel.green < pixel.blue) ? pixel.green : pixel.blue;
    assign mn          = (pixel.red < mn_bg) ? pixel.red : mn_bg;
    assign first_pix   = (in_line_reg == '0) && (in_col_reg == '0);
    assign out_free    = !out_valid_reg || result.ready;

    // line banks
    logic [WIN-1:0][DATA_W-1:0] bank_q, bank_m;
    logic [CW-1:0]              ram_addr;
    assign ram_addr = (state_reg == S_WR) ? in_col_reg : cm_col_reg;

    // vertical window bounds
    logic [LW-1:0] v_lo, v_hi, v_span;
    logic [BW:0]   lo_mod;
    always_comb
    begin
        v_lo = (cm_line_reg >= LW'(fr_reg)) ? cm_line_reg - LW'(fr_reg) : '0;
        v_hi = ((cm_line_reg + LW'(fr_reg)) > (fh_reg - 1'b1)) ?
               fh_reg - 1'b1 : cm_line_reg + LW'(fr_reg);
        v_span = v_hi - v_lo;
        if (cm_line_reg < LW'(fr_reg))
        begin
            lo_mod = '0;
        end
        else if ({1'b0, cm_mod_reg} >= (BW+1)'(fr_reg))
        begin
            lo_mod = {1'b0, cm_mod_reg} - (BW+1)'(fr_reg);
        end
        else
        begin
            lo_mod = {1'b0, cm_mod_reg} + (BW+1)'(WIN) - (BW+1)'(fr_reg);
        end
    end

    genvar b;
    generate
        for (b = 0; b < WIN; b++)
        begin : g_bank
            logic [BW:0] bank_ofs;
            assign bank_ofs = ((BW+1)'(b) >= lo_mod) ? (BW+1)'(b) - lo_mod
                                                     : (BW+1)'(b) + (BW+1)'(WIN) - lo_mod;
            assign bank_m[b] = (LW'(bank_ofs) <= v_span) ? bank_q[b] : PIX_MAX;
            dcmf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_bank (
                .clk   (clk),
                .we    ((state_reg == S_WR) && (in_mod_reg == BW'(b))),
                .addr  (ram_addr),
                .wdata (mn_reg),
                .rdata (bank_q[b])
            );
        end
    endgenerate

    pix_t vmin;
    dcmf_min_tree #(.N(WIN)) u_vtree (.din(bank_m), .dout(vmin));

    // horizontal window chain
    logic [CW:0]   need, left_n, right_n;
    logic [KW-1:0] klo, khi;
    logic          avail;
    always_comb
    begin
        need = ({1'b0, out_col_reg} + (CW+1)'(fr_reg) > fw_reg - 1'b1) ?
               fw_reg - 1'b1 : {1'b0, out_col_reg} + (CW+1)'(fr_reg);
        left_n = ({1'b0, out_col_reg} < (CW+1)'(fr_reg)) ?
                 {1'b0, out_col_reg} : (CW+1)'(fr_reg);
        right_n = need - {1'b0, out_col_reg};
        khi = lead_reg - 1'b1 + KW'(left_n);
        klo = lead_reg - 1'b1 - KW'(right_n);
        avail = (cm_line_reg > out_line_reg) ||
                ((cm_line_reg == out_line_reg) && ({1'b0, cm_col_reg} > need));
    end

    logic                       shift;
    logic [WIN-1:0][DATA_W-1:0] cell_q, cell_m;
    assign shift = (state_reg == S_SH);

    genvar k;
    generate
        for (k = 0; k < WIN; k++)
        begin : g_cell
            dcmf_cell #(.K(k), .KW(KW)) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (shift),
                .d      ((k == 0) ? vmin_reg : cell_q[(k == 0) ? 0 : k-1]),
                .klo    (klo),
                .khi    (khi),
                .q      (cell_q[k]),
                .masked (cell_m[k])
            );
        end
    endgenerate

    pix_t hmin;
    dcmf_min_tree #(.N(WIN)) u_htree (.din(cell_m), .dout(hmin));

    logic eol, eof, do_emit;
    assign eol     = ({1'b0, out_col_reg} == fw_reg - 1'b1);
    assign eof     = eol && (out_line_reg == fh_reg - 1'b1);
    assign do_emit = (state_reg == S_EMIT) && (out_line_reg < fh_reg) && avail && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !draining_reg && pixel.cmd == CMD_PIXEL)
                begin
                    state_next = S_WR;
                end
                else if (accept && draining_reg && pixel.cmd == CMD_FLUSH)
                begin
                    state_next = (cm_line_reg < fh_reg) ? S_RD : S_EMIT;
                end
            end
            S_WR:    state_next = (in_line_reg >= LW'(fr_reg)) ? S_RD : S_EMIT;
            S_RD:    state_next = S_VM;
            S_VM:    state_next = S_SH;
            S_SH:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free || !(out_line_reg < fh_reg) || !avail)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_w_reg     <= CFG_W'(1024);
            cfg_h_reg     <= CFG_W'(1024);
            cfg_r_reg     <= RAD_CFG_W'(7);
            fw_reg        <= (CW+1)'(MAX_WIDTH);
            fh_reg        <= LW'(MAX_HEIGHT);
            fr_reg        <= RW'(MAX_RADIUS);
            in_col_reg    <= '0;
            in_line_reg   <= '0;
            in_mod_reg    <= '0;
            cm_col_reg    <= '0;
            cm_line_reg   <= '0;
            cm_mod_reg    <= '0;
            out_col_reg   <= '0;
            out_line_reg  <= '0;
            lead_reg      <= '0;
            draining_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  cfg_w_reg <= cfg_data;
                    REG_IMAGE_HEIGHT: cfg_h_reg <= cfg_data;
                    REG_PATCH_RADIUS: cfg_r_reg <= cfg_data[RAD_CFG_W-1:0];
                    default:          ;
                endcase
            end
            if (do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // latch frame sizes and radius at the first pixel
            if (accept && !draining_reg && pixel.cmd == CMD_PIXEL && first_pix)
            begin
                if (cfg_w_reg == '0)
                    fw_reg <= (CW+1)'(1);
                else if (32'(cfg_w_reg) > 32'(MAX_WIDTH))
                    fw_reg <= (CW+1)'(MAX_WIDTH);
                else
                    fw_reg <= (CW+1)'(cfg_w_reg);
                if (cfg_h_reg == '0)
                    fh_reg <= LW'(1);
                else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT))
                    fh_reg <= LW'(MAX_HEIGHT);
                else
                    fh_reg <= LW'(cfg_h_reg);
                if (32'(cfg_r_reg) > 32'(MAX_RADIUS))
                    fr_reg <= RW'(MAX_RADIUS);
                else
                    fr_reg <= RW'(cfg_r_reg);
                out_col_reg  <= '0;
                out_line_reg <= '0;
                cm_col_reg   <= '0;
                cm_line_reg  <= '0;
                cm_mod_reg   <= '0;
                lead_reg     <= '0;
            end
            // advance input position
            if (state_reg == S_WR)
            begin
                if ({1'b0, in_col_reg} + 1'b1 >= fw_reg)
                begin
                    in_col_reg <= '0;
                    if (in_line_reg + 1'b1 >= fh_reg)
                    begin
                        in_line_reg  <= '0;
                        in_mod_reg   <= '0;
                        draining_reg <= 1'b1;
                    end
                    else
                    begin
                        in_line_reg <= in_line_reg + 1'b1;
                        in_mod_reg  <= (in_mod_reg == BW'(WIN-1)) ? '0 : in_mod_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            // advance column-minimum producer
            if (state_reg == S_SH)
            begin
                lead_reg <= lead_reg + 1'b1;
                if ({1'b0, cm_col_reg} + 1'b1 >= fw_reg)
                begin
                    cm_col_reg  <= '0;
                    cm_line_reg <= cm_line_reg + 1'b1;
                    cm_mod_reg  <= (cm_mod_reg == BW'(WIN-1)) ? '0 : cm_mod_reg + 1'b1;
                end
                else
                begin
                    cm_col_reg <= cm_col_reg + 1'b1;
                end
            end
            if (do_emit)
            begin
                if (eof)
                begin
                    draining_reg <= 1'b0;
                    in_col_reg   <= '0;
                    in_line_reg  <= '0;
                    in_mod_reg   <= '0;
                    out_col_reg  <= '0;
                    out_line_reg <= '0;
                    cm_col_reg   <= '0;
                    cm_line_reg  <= '0;
                    cm_mod_reg   <= '0;
                    lead_reg     <= '0;
                end
                else
                begin
                    lead_reg <= lead_reg - 1'b1;
                    if (eol)
                    begin
                        out_col_reg  <= '0;
                        out_line_reg <= out_line_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mn_reg <= mn;
        end
        if (state_reg == S_VM)
        begin
            vmin_reg <= vmin;
        end
        if (do_emit)
        begin
            dark_reg <= hmin;
            eol_reg  <= eol;
            eof_reg  <= eof;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.dark         = dark_reg;
    assign result.end_of_line  = eol_reg;
    assign result.end_of_frame = eof_reg;
endmodule

// File: sv/dcmf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sv/dcmf_min_tree.sv
// Balanced minimum tree over N byte values, padded with the maximum value.
// Depends on dcmf_pkg.
module dcmf_min_tree
    import dcmf_pkg::*;
#(
    parameter int N = 15
) (
    input  logic [N-1:0][DATA_W-1:0] din,
    output pix_t                     dout
);
    localparam int P = (N < 2) ? 2 : (1 << $clog2(N));

    pix_t node [2*P];

    genvar i;
    generate
        for (i = 0; i < P; i++)
        begin : g_leaf
            if (i < N)
            begin : g_used
                assign node[P+i] = din[i];
            end
            else
            begin : g_pad
                assign node[P+i] = PIX_MAX;
            end
        end
        for (i = 1; i < P; i++)
        begin : g_node
            assign node[i] = (node[2*i] < node[2*i+1]) ? node[2*i] : node[2*i+1];
        end
    endgenerate

    assign node[0] = PIX_MAX;
    assign dout    = node[1];
endmodule

// File: sv/dcmf_cell.sv
// One cell of the horizontal window chain: holds one column minimum,
// takes its neighbor's value on a shift and masks itself outside the window.
// Depends on dcmf_pkg.
module dcmf_cell
    import dcmf_pkg::*;
#(
    parameter int K  = 0,
    parameter int KW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  pix_t          d,
    input  logic [KW-1:0] klo,
    input  logic [KW-1:0] khi,
    output pix_t          q,
    output pix_t          masked
);
    localparam logic [KW-1:0] IDX = KW'(K);

    pix_t val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= PIX_MAX;
        end
        else if (shift)
        begin
            val_reg <= d;
        end
    end

    assign q      = val_reg;
    assign masked = (IDX >= klo && IDX <= khi) ? val_reg : PIX_MAX;
endmodule
